// ----- hw/rtl/dvtu_pkg.sv -----
// ----------------------------------------------------------------------------
// dvtu_pkg
// Shared types and constants of the distance-vector table update engine.
// ----------------------------------------------------------------------------
package dvtu_pkg;

  localparam int NODE_COUNT = 16;
  localparam int DIST_BITS  = 16;
  localparam int NODE_BITS  = 4;
  localparam int HOP_BITS   = 5;

  localparam logic [DIST_BITS-1:0] DIST_UNREACH = {DIST_BITS{1'b1}};
  localparam logic [HOP_BITS-1:0]  NO_ROUTE     = HOP_BITS'(NODE_COUNT);

  // operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // register index of own_index
  localparam logic REG_OWN_INDEX = 1'b0;

  typedef struct packed {
    logic                 operation;
    logic [NODE_BITS-1:0] sender;
    logic [15:0]          link_cost;
    logic [NODE_BITS-1:0] dest;
    logic [DIST_BITS-1:0] advertised_distance;
    logic                 last;
  } in_item_t;

  typedef struct packed {
    logic [NODE_BITS-1:0] entry_dest;
    logic [DIST_BITS-1:0] entry_distance;
    logic [HOP_BITS-1:0]  entry_next_hop;
    logic                 updated;
    logic                 vector_changed;
    logic                 result_last;
  } out_item_t;

  // class of a queued item as decided by the front end
  typedef enum logic [1:0] {
    KIND_OWN,
    KIND_NO_DEST,
    KIND_RELAX,
    KIND_LOOKUP
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic                 is_update;
    logic [NODE_BITS-1:0] dest;
    logic [NODE_BITS-1:0] sender;
    logic [DIST_BITS-1:0] via;
    logic                 last;
  } work_t;

endpackage

// ----- hw/rtl/dvtu_fifo.sv -----
// ----------------------------------------------------------------------------
// dvtu_fifo
// Small register-based queue with full and empty flags.
// ----------------------------------------------------------------------------
module dvtu_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/dvtu_front.sv -----
// ----------------------------------------------------------------------------
// dvtu_front
// Classify an incoming item and form its saturated path cost.
// ----------------------------------------------------------------------------
module dvtu_front (
  input  dvtu_pkg::in_item_t              request,
  input  logic [dvtu_pkg::NODE_BITS-1:0]  own_index,
  output dvtu_pkg::work_t                 work
);
  import dvtu_pkg::*;

  logic [DIST_BITS:0] sum;
  logic [DIST_BITS-1:0] via;
  logic is_update;
  logic sender_ok;

  assign sum       = {1'b0, DIST_BITS'(request.link_cost)}
                   + {1'b0, request.advertised_distance};
  assign is_update = (request.operation == OP_UPDATE);
  assign sender_ok = (int'(request.sender) < NODE_COUNT);

  // saturate to the unreachable code
  always_comb begin
    if (request.advertised_distance == DIST_UNREACH) begin
      via = DIST_UNREACH;
    end else if (sum >= {1'b0, DIST_UNREACH}) begin
      via = DIST_UNREACH;
    end else begin
      via = sum[DIST_BITS-1:0];
    end
  end

  always_comb begin
    work.is_update = is_update;
    work.dest      = request.dest;
    work.sender    = request.sender;
    work.via       = via;
    work.last      = request.last;
    priority if (request.dest == own_index) begin
      work.kind = KIND_OWN;
    end else if (int'(request.dest) >= NODE_COUNT) begin
      work.kind = KIND_NO_DEST;
    end else if (is_update && sender_ok) begin
      work.kind = KIND_RELAX;
    end else begin
      work.kind = KIND_LOOKUP;
    end
  end

endmodule

// ----- hw/rtl/dvtu_back.sv -----
// ----------------------------------------------------------------------------
// dvtu_back
// Relax one table entry per item and build the result item.
// ----------------------------------------------------------------------------
module dvtu_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            valid,
  input  dvtu_pkg::work_t                 work,
  input  logic [dvtu_pkg::NODE_BITS-1:0]  own_index,
  output dvtu_pkg::out_item_t             result
);
  import dvtu_pkg::*;

  logic [DIST_BITS-1:0] distance_table [NODE_COUNT];
  logic [HOP_BITS-1:0]  next_hop_table [NODE_COUNT];
  logic                 change_acc;

  logic [DIST_BITS-1:0] dist_rd;
  logic [HOP_BITS-1:0]  hop_rd;
  logic                 lower;
  logic                 change_any;

  assign dist_rd    = distance_table[work.dest];
  assign hop_rd     = next_hop_table[work.dest];
  assign lower      = (work.kind == KIND_RELAX) && (work.via < dist_rd);
  assign change_any = change_acc || lower;

  always_comb begin
    result.entry_dest     = work.dest;
    result.updated        = lower;
    result.result_last    = work.last;
    result.vector_changed = work.is_update && work.last && change_any;
    unique case (work.kind)
      KIND_OWN: begin
        result.entry_distance = '0;
        result.entry_next_hop = HOP_BITS'(own_index);
      end
      KIND_NO_DEST: begin
        result.entry_distance = DIST_UNREACH;
        result.entry_next_hop = NO_ROUTE;
      end
      KIND_RELAX: begin
        result.entry_distance = lower ? work.via : dist_rd;
        result.entry_next_hop = lower ? HOP_BITS'(work.sender) : hop_rd;
      end
      default: begin
        result.entry_distance = dist_rd;
        result.entry_next_hop = hop_rd;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        distance_table[i] <= DIST_UNREACH;
        next_hop_table[i] <= NO_ROUTE;
      end
      change_acc <= 1'b0;
    end else if (valid) begin
      if (lower) begin
        distance_table[work.dest] <= work.via;
        next_hop_table[work.dest] <= HOP_BITS'(work.sender);
      end
      // close the vector on its last element
      if (work.is_update) begin
        change_acc <= work.last ? 1'b0 : change_any;
      end
    end
  end

endmodule

// ----- hw/rtl/distance_vector_table_update.sv -----
// Path: an accepted item is held in the work queue; the back end then writes
//   its result into the result queue, from which it can be popped.
// Throughput: one item per cycle while the result queue has room, set by the
//   back end's table read, compare and write, whose write the next item sees.
// Reset: synchronous; both queues empty, every table entry unreachable with
//   no route, own_index 0, no clearing pass.
// ----------------------------------------------------------------------------
// distance_vector_table_update
// Distance-vector routing table engine for one router. Update items relax
// one entry with the sender's advertised distance plus the link cost; read
// items report one entry. A front end classifies each item and computes the
// saturated path cost, a two-entry queue decouples it from the back end that
// owns the tables, and a two-entry result queue decouples the consumer.
// ----------------------------------------------------------------------------
module distance_vector_table_update (
  input  logic                 clk,
  input  logic                 rst,
  // item side
  input  logic                 push,
  output logic                 full,
  input  dvtu_pkg::in_item_t   request,
  // result side
  output logic                 empty,
  input  logic                 pop,
  output dvtu_pkg::out_item_t  result,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import dvtu_pkg::*;

  localparam int WORK_W = $bits(work_t);
  localparam int OUT_W  = $bits(out_item_t);

  logic [NODE_BITS-1:0] own_index;
  work_t                work_in;
  work_t                work_q;
  logic                 work_empty;
  logic                 out_full;
  logic                 back_go;
  out_item_t            back_result;
  logic [OUT_W-1:0]     result_bits;
  logic [WORK_W-1:0]    work_bits;

  // Configuration: single register, own_index, at addresses 0 to 3 (paddr[2] low).
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_index <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_OWN_INDEX)) begin
      own_index <= pwdata[NODE_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OWN_INDEX) begin
      prdata[NODE_BITS-1:0] = own_index;
    end
  end

  // Front end: classify and form the candidate distance.
  dvtu_front u_front (
    .request   (request),
    .own_index (own_index),
    .work      (work_in)
  );

  // Work queue between front and back.
  dvtu_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (2)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (work_in),
    .full    (full),
    .rd_en   (back_go),
    .rd_data (work_bits),
    .empty   (work_empty)
  );

  assign work_q = work_t'(work_bits);

  // Advance the back end whenever there is work and room for its result.
  assign back_go = !work_empty && !out_full;

  dvtu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .valid     (back_go),
    .work      (work_q),
    .own_index (own_index),
    .result    (back_result)
  );

  // Result queue; hold results until popped.
  dvtu_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (2)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (back_go),
    .wr_data (back_result),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (result_bits),
    .empty   (empty)
  );

  assign result = out_item_t'(result_bits);

  // A lowered entry is always reachable and routed.
  a_upd_reachable: assert property (@(posedge clk) disable iff (rst)
    !empty && result.updated |-> result.entry_distance != DIST_UNREACH &&
                                 result.entry_next_hop != NO_ROUTE)
    else $error("updated result carries unreachable distance or no route");

  // The change flag only closes a vector.
  a_vchg_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.vector_changed |-> result.result_last)
    else $error("vector_changed without last");

  // Next hop is a node index or the no-route code.
  a_hop_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.entry_next_hop <= NO_ROUTE)
    else $error("next hop out of range");

  // The back end never advances into a full result queue.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    back_go |-> !out_full && !work_empty)
    else $error("back end advanced without room or work");

endmodule
